>>> hdl/lir_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and word types of the linear interpolation resampler.
package lir_pkg;

    localparam int SMP_W        = 24;
    localparam int RATE_W       = 18;
    localparam int S_W          = 17;
    localparam int FRAC_W       = 16;
    localparam int CNT_W        = 20;
    localparam int STEP_W       = S_W + FRAC_W;
    localparam int ACC_W        = STEP_W + 1;
    localparam int PROD_W       = S_W + RATE_W;

    localparam int MAX_FRAMES   = 65536;
    localparam int MAX_UPSAMPLE = 8;
    localparam int MAX_RESULTS  = 16;
    localparam int QUEUE_DEPTH  = 2;

    localparam int N_W          = $clog2(MAX_RESULTS + 1);
    localparam int UPS_W        = $clog2(MAX_UPSAMPLE + 1);
    localparam int LIM_W        = RATE_W + UPS_W;
    localparam int FRAMES_CAP   = (MAX_FRAMES > 2**S_W - 1) ? 2**S_W - 1 : MAX_FRAMES;

    localparam logic [CNT_W-1:0]  COUNT_MAX  = {CNT_W{1'b1}};
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

    localparam int CFG_W = 2;
    localparam logic [CFG_W-1:0] CFG_SOURCE_RATE   = 2'd0;
    localparam logic [CFG_W-1:0] CFG_TARGET_RATE   = 2'd1;
    localparam logic [CFG_W-1:0] CFG_SOURCE_FRAMES = 2'd2;

    typedef enum logic [1:0] {
        MODE_INTERP = 2'd0,
        MODE_PASS   = 2'd1,
        MODE_REJECT = 2'd2
    } t_mode;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_in;
        logic signed [SMP_W-1:0] right_in;
    } t_in_word;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_out;
        logic signed [SMP_W-1:0] right_out;
        logic                    last_of_clip;
        logic                    status;
    } t_out_word;

    // one classified source frame, with the settings of its clip
    typedef struct packed {
        t_in_word           word;
        logic [S_W-1:0]     k;
        logic               last_frame;
        t_mode              mode;
        logic [CNT_W-1:0]   t_count;
        logic [STEP_W-1:0]  step;
    } t_entry;

endpackage

>>> hdl/lir_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by the clip setup.
module lir_div import lir_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quotient
);

    localparam int ITER_W = $clog2(PROD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_iter;
    logic [PROD_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W:0]    trial;
    logic              take;
    logic [CNT_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_quo[PROD_W-1]};
        take  = (trial >= {1'b0, r_div});
        n_rem = take ? CNT_W'(trial - {1'b0, r_div}) : trial[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_iter <= ITER_W'(PROD_W);
            end else if (r_busy) begin
                r_iter <= r_iter - 1'b1;
                if (r_iter == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[PROD_W-2:0], take};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> hdl/lir_queue.sv
`timescale 1ns / 1ps
// Small FIFO of classified frames between the front and back ends.
module lir_queue import lir_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    output logic   o_space,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QC_W  = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [QC_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_space = (r_count != QC_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != QC_W'(DEPTH) || i_pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");
`endif

endmodule

>>> hdl/lir_front.sv
`timescale 1ns / 1ps
// Front end: register file, clip setup with shared divider, frame classification.
module lir_front import lir_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_index,
    input  logic [RATE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_word,
    output logic              o_push,
    output t_entry            o_entry,
    input  logic              i_space
);

    typedef enum logic [4:0] {
        F_IDLE  = 5'b00001,
        F_SETUP = 5'b00010,
        F_DIV_T = 5'b00100,
        F_DIV_S = 5'b01000,
        F_PUSH  = 5'b10000
    } t_fstate;

    t_fstate           r_state, n_state;
    logic [RATE_W-1:0] r_src_rate;
    logic [RATE_W-1:0] r_tgt_rate;
    logic [S_W-1:0]    r_src_frames;
    logic [S_W-1:0]    r_frames_in;
    logic [S_W-1:0]    r_clip_frames;
    t_mode             r_mode;
    logic [RATE_W-1:0] r_sr;
    logic [RATE_W-1:0] r_tr;
    logic [CNT_W-1:0]  r_t;
    logic [STEP_W-1:0] r_step;
    t_in_word          r_word;

    logic              first_in;
    logic              accept;
    logic [RATE_W-1:0] sr_eff, tr_eff;
    logic [S_W-1:0]    s_eff;
    logic [LIM_W-1:0]  up_lim;
    t_mode             mode_new;
    logic [S_W:0]      k_next;
    logic              last;
    logic [PROD_W-1:0] prod;
    logic              div_start, div_done;
    logic [PROD_W-1:0] div_dividend, div_quo;
    logic [CNT_W-1:0]  div_divisor;
    logic [CNT_W-1:0]  t_sat;

    always_comb begin
        first_in   = (r_frames_in == '0);
        o_in_ready = (r_state == F_IDLE) && (first_in || i_space);
        accept     = i_in_valid && o_in_ready;

        sr_eff = (r_src_rate == '0) ? RATE_W'(1) : r_src_rate;
        tr_eff = (r_tgt_rate == '0) ? RATE_W'(1) : r_tgt_rate;
        if (r_src_frames == '0) begin
            s_eff = S_W'(1);
        end else if (r_src_frames > S_W'(FRAMES_CAP)) begin
            s_eff = S_W'(FRAMES_CAP);
        end else begin
            s_eff = r_src_frames;
        end
        up_lim = LIM_W'(sr_eff) * LIM_W'(MAX_UPSAMPLE);
        if (LIM_W'(tr_eff) > up_lim) begin
            mode_new = MODE_REJECT;
        end else if (tr_eff == sr_eff) begin
            mode_new = MODE_PASS;
        end else begin
            mode_new = MODE_INTERP;
        end

        k_next = {1'b0, r_frames_in} + 1'b1;
        last   = (k_next >= {1'b0, r_clip_frames});

        prod  = {{RATE_W{1'b0}}, r_clip_frames} * {{S_W{1'b0}}, r_tr};
        t_sat = (div_quo > PROD_W'(COUNT_MAX)) ? COUNT_MAX : div_quo[CNT_W-1:0];

        // frame count division first, then position step
        div_start = ((r_state == F_SETUP) && (r_mode == MODE_INTERP))
                 || ((r_state == F_DIV_T) && div_done && (t_sat >= CNT_W'(2)));
        if (r_state == F_SETUP) begin
            div_dividend = prod;
            div_divisor  = CNT_W'(r_sr);
        end else begin
            div_dividend = PROD_W'({r_clip_frames, FRAC_W'(0)});
            div_divisor  = t_sat - 1'b1;
        end

        o_push = ((r_state == F_IDLE) && accept && !first_in)
              || ((r_state == F_PUSH) && i_space);
        o_entry.word       = (r_state == F_PUSH) ? r_word : i_in_word;
        o_entry.k          = r_frames_in;
        o_entry.last_frame = last;
        o_entry.mode       = r_mode;
        o_entry.t_count    = r_t;
        o_entry.step       = r_step;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept && first_in) begin
                    n_state = F_SETUP;
                end
            end
            F_SETUP: begin
                n_state = (r_mode == MODE_INTERP) ? F_DIV_T : F_PUSH;
            end
            F_DIV_T: begin
                if (div_done) begin
                    n_state = (t_sat >= CNT_W'(2)) ? F_DIV_S : F_PUSH;
                end
            end
            F_DIV_S: begin
                if (div_done) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (i_space) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= F_IDLE;
            r_src_rate    <= RATE_RESET;
            r_tgt_rate    <= RATE_RESET;
            r_src_frames  <= S_W'(1);
            r_frames_in   <= '0;
            r_clip_frames <= S_W'(1);
            r_mode        <= MODE_PASS;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SOURCE_RATE:   r_src_rate   <= i_cfg_data;
                    CFG_TARGET_RATE:   r_tgt_rate   <= i_cfg_data;
                    CFG_SOURCE_FRAMES: r_src_frames <= i_cfg_data[S_W-1:0];
                    default: ;
                endcase
            end
            if (accept && first_in) begin
                r_clip_frames <= s_eff;
                r_mode        <= mode_new;
            end
            if (o_push) begin
                r_frames_in <= last ? '0 : k_next[S_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && first_in) begin
            r_word <= i_in_word;
            r_sr   <= sr_eff;
            r_tr   <= tr_eff;
        end
        if ((r_state == F_DIV_T) && div_done) begin
            r_t <= t_sat;
            if (t_sat < CNT_W'(2)) begin
                r_step <= '0;
            end
        end
        if ((r_state == F_DIV_S) && div_done) begin
            r_step <= div_quo[STEP_W-1:0];
        end
    end

    assign o_cfg_ready = 1'b1;

    lir_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

`ifndef SYNTH
    a_div_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == F_DIV_T || r_state == F_DIV_S))
        else $error("divider finished with no setup waiting on it");
`endif

endmodule

>>> hdl/lir_back.sv
`timescale 1ns / 1ps
// Back end: walks output positions per frame, blends; an interp frame gives one result per cycle while ready.
module lir_back import lir_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_entry    i_entry,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int BL_W = SMP_W + FRAC_W + 2;
    localparam logic signed [BL_W-1:0] HALF = BL_W'(2**(FRAC_W - 1));

    logic                    r_busy;
    t_entry                  r_e;
    logic signed [SMP_W-1:0] r_prev_l, r_prev_r;
    logic signed [SMP_W:0]   r_dl, r_dr;
    logic [CNT_W-1:0]        r_fo;
    logic [ACC_W-1:0]        r_acc;
    logic [N_W-1:0]          r_n;
    logic                    r_ovalid;
    t_out_word               r_out;

    logic                    load, interp, room, more, emit, finish, at_pos;
    logic [ACC_W-1:0]        kpos;
    logic [FRAC_W-1:0]       frac;
    logic signed [BL_W-1:0]  prod_l, prod_r, sum_l, sum_r;
    t_out_word               n_out;

    always_comb begin
        load   = !r_busy && i_valid;
        interp = (r_e.mode == MODE_INTERP);
        kpos   = ACC_W'({r_e.k, FRAC_W'(0)});
        room   = !r_ovalid || i_out_ready;
        // next output owed now unless past a non-final frame, target count met or result cap hit
        more   = (r_fo < r_e.t_count) && (r_n < N_W'(MAX_RESULTS))
              && (r_e.last_frame || (r_acc <= kpos));
        emit   = r_busy && room && (!interp || more);
        finish = r_busy && (interp ? !more : room);
        at_pos = (r_acc >= kpos);

        frac   = r_acc[FRAC_W-1:0];
        prod_l = r_dl * $signed({1'b0, frac});
        prod_r = r_dr * $signed({1'b0, frac});
        sum_l  = prod_l + (BL_W'(r_prev_l) <<< FRAC_W) + HALF;
        sum_r  = prod_r + (BL_W'(r_prev_r) <<< FRAC_W) + HALF;

        n_out.left_out     = r_e.word.left_in;
        n_out.right_out    = r_e.word.right_in;
        n_out.last_of_clip = r_e.last_frame;
        n_out.status       = 1'b0;
        if (r_e.mode == MODE_REJECT) begin
            n_out.left_out  = '0;
            n_out.right_out = '0;
            n_out.status    = 1'b1;
        end else if (interp) begin
            if (!at_pos) begin
                n_out.left_out  = sum_l[FRAC_W +: SMP_W];
                n_out.right_out = sum_r[FRAC_W +: SMP_W];
            end
            n_out.last_of_clip = (({1'b0, r_fo} + 1'b1) == {1'b0, r_e.t_count});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_fo     <= '0;
            r_acc    <= '0;
            r_n      <= '0;
            r_prev_l <= '0;
            r_prev_r <= '0;
        end else begin
            r_ovalid <= emit || (r_ovalid && !i_out_ready);
            if (load) begin
                r_busy <= 1'b1;
                r_n    <= '0;
                if (i_entry.k == '0) begin
                    r_fo  <= '0;
                    r_acc <= '0;
                end
            end
            if (emit && interp) begin
                r_acc <= r_acc + ACC_W'(r_e.step);
                r_fo  <= r_fo + 1'b1;
                r_n   <= r_n + 1'b1;
            end
            if (finish) begin
                r_busy   <= 1'b0;
                r_prev_l <= r_e.word.left_in;
                r_prev_r <= r_e.word.right_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_e  <= i_entry;
            r_dl <= (SMP_W + 1)'(i_entry.word.left_in) - (SMP_W + 1)'(r_prev_l);
            r_dr <= (SMP_W + 1)'(i_entry.word.right_in) - (SMP_W + 1)'(r_prev_r);
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_pop       = load;
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

`ifndef SYNTH
    a_result_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_n <= N_W'(MAX_RESULTS)))
        else $error("more results than allowed for one frame");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_e.mode == MODE_INTERP) |-> (r_fo <= r_e.t_count))
        else $error("clip emitted beyond its target length");
`endif

endmodule

>>> hdl/linear_interp_resampler_unit.sv
`timescale 1ns / 1ps
// A clip's first word passes the setup state, its divisions (none for pass or
// reject, one when under two results are owed, else two) and the push state to reach the queue;
// other words reach it when accepted. The back end loads a word into its entry register, then registers each result.
// Throughput: the back end loads a new word only once it is done with the last, and its one
// blend datapath gives 1 result/cycle while an interpolated word is owed results and the output is ready.
// Reset: synchronous, active low; clears counters and handshakes, rates 48000, clip length 1.
module linear_interp_resampler_unit import lir_pkg::*; #(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_index,
    input  logic [RATE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_word
);

    logic   q_push, q_space, q_pop, q_valid;
    t_entry q_wdata, q_rdata;

    lir_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_push      (q_push),
        .o_entry     (q_wdata),
        .i_space     (q_space)
    );

    lir_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_space (q_space),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    lir_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_entry     (q_rdata),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

>>> tb/sv/tb_linear_interp_resampler_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the linear interpolation resampler: directed table, then random clips.
module tb_linear_interp_resampler_unit;
    import lir_pkg::*;

    localparam int LIMIT       = 1000000;
    localparam int SETTLE      = 120;   // setup divisions plus back end drain
    localparam int RANDOM_WORDS = 350;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_FRAME,
        ROW_TYPED
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [CFG_W-1:0]  idx;
        logic [RATE_W-1:0] data;
        t_in_word          w;
        t_out_word         want;
    } t_row;

    // typed rows carry the word the block must return; the rest go through the predictor
    localparam t_row DIRECTED [37] = '{
        '{ROW_TYPED, '0, '0, {24'h7FFFFF, 24'h800000}, {24'h7FFFFF, 24'h800000, 1'b1, 1'b0}},
        '{ROW_TYPED, '0, '0, {24'h800000, 24'h7FFFFF}, {24'h800000, 24'h7FFFFF, 1'b1, 1'b0}},
        '{ROW_TYPED, '0, '0, {24'h000000, 24'hFFFFFF}, {24'h000000, 24'hFFFFFF, 1'b1, 1'b0}},
        '{ROW_CFG, CFG_SOURCE_RATE, 18'd0, '0, '0},
        '{ROW_CFG, CFG_TARGET_RATE, 18'h3FFFF, '0, '0},
        '{ROW_TYPED, '0, '0, {24'h123456, 24'hFEDCBA}, {24'h000000, 24'h000000, 1'b1, 1'b1}},
        '{ROW_TYPED, '0, '0, {24'hAAAAAA, 24'h555555}, {24'h000000, 24'h000000, 1'b1, 1'b1}},
        '{ROW_CFG, CFG_SOURCE_RATE, 18'd1, '0, '0},
        '{ROW_CFG, CFG_TARGET_RATE, 18'd9, '0, '0},
        '{ROW_TYPED, '0, '0, {24'h555555, 24'hAAAAAA}, {24'h000000, 24'h000000, 1'b1, 1'b1}},
        '{ROW_CFG, CFG_TARGET_RATE, 18'd8, '0, '0},
        '{ROW_FRAME, '0, '0, {24'h7FFFFF, 24'h800000}, '0},
        '{ROW_CFG, CFG_SOURCE_FRAMES, 18'd0, '0, '0},
        '{ROW_CFG, CFG_SOURCE_RATE, 18'd3, '0, '0},
        '{ROW_CFG, CFG_TARGET_RATE, 18'd2, '0, '0},
        '{ROW_FRAME, '0, '0, {24'h400000, 24'hC00000}, '0},
        '{ROW_CFG, CFG_SOURCE_FRAMES, 18'd2, '0, '0},
        '{ROW_CFG, CFG_SOURCE_RATE, 18'd2, '0, '0},
        '{ROW_CFG, CFG_TARGET_RATE, 18'd1, '0, '0},
        '{ROW_FRAME, '0, '0, {24'h7FFFFF, 24'h7FFFFF}, '0},
        '{ROW_FRAME, '0, '0, {24'h800000, 24'h800000}, '0},
        '{ROW_CFG, CFG_SOURCE_FRAMES, 18'd4, '0, '0},
        '{ROW_CFG, CFG_SOURCE_RATE, 18'd1, '0, '0},
        '{ROW_CFG, CFG_TARGET_RATE, 18'd3, '0, '0},
        '{ROW_FRAME, '0, '0, {24'h800000, 24'h7FFFFF}, '0},
        '{ROW_FRAME, '0, '0, {24'h7FFFFF, 24'h800000}, '0},
        '{ROW_FRAME, '0, '0, {24'h800000, 24'h7FFFFF}, '0},
        '{ROW_FRAME, '0, '0, {24'h000001, 24'hFFFFFF}, '0},
        '{ROW_CFG, CFG_SOURCE_FRAMES, 18'd6, '0, '0},
        '{ROW_CFG, CFG_SOURCE_RATE, 18'd3, '0, '0},
        '{ROW_CFG, CFG_TARGET_RATE, 18'd1, '0, '0},
        '{ROW_FRAME, '0, '0, {24'h100000, 24'hF00000}, '0},
        '{ROW_FRAME, '0, '0, {24'h7FFFFF, 24'h800000}, '0},
        '{ROW_FRAME, '0, '0, {24'h000000, 24'h000000}, '0},
        '{ROW_FRAME, '0, '0, {24'h800000, 24'h7FFFFF}, '0},
        '{ROW_FRAME, '0, '0, {24'h0ABCDE, 24'hF54321}, '0},
        '{ROW_FRAME, '0, '0, {24'h7FFFFF, 24'h7FFFFF}, '0}
    };

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_index = '0;
    logic [RATE_W-1:0] i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_word          i_in_word   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_word         o_out_word;

    linear_interp_resampler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #10 i_clk = ~i_clk;

    // predictor copy of the registers and clip state
    logic [RATE_W-1:0] cfg_src_rate   = RATE_RESET;
    logic [RATE_W-1:0] cfg_tgt_rate   = RATE_RESET;
    logic [S_W-1:0]    cfg_src_frames = 1;
    longint            prev_l = 0, prev_r = 0;
    longint unsigned   frames_in = 0, frames_out = 0, pos_acc = 0, pos_step = 0;
    longint unsigned   tgt_count = 0, clip_len = 1;
    t_mode             clip_mode = MODE_PASS;

    t_out_word owed_words[$];
    int        mismatches    = 0;
    int        words_checked = 0;
    int        frames_sent   = 0;
    int        clip_count    = 0;
    int        mode_seen[3]  = '{0, 0, 0};
    int        cycles        = 0;
    int        burst_left    = 1;
    int        gap_max       = 3;
    logic [1:0] rx_mode      = 2'd0;
    logic [7:0] rx_pat       = 8'hFF;

    function automatic void resample_frame(t_in_word w, bit typed, t_out_word typed_word);
        longint          cl, cr, lo, ro;
        longint unsigned s, sr, tr, t, kpos, frac;
        bit              at_end;
        int              n;
        t_out_word       o;
        cl = w.left_in;
        cr = w.right_in;
        n  = 0;
        if (frames_in == 0) begin
            s  = cfg_src_frames;
            sr = (cfg_src_rate == 0) ? 1 : cfg_src_rate;
            tr = (cfg_tgt_rate == 0) ? 1 : cfg_tgt_rate;
            if (s < 1) s = 1;
            if (s > MAX_FRAMES) s = MAX_FRAMES;
            clip_len = s;
            if (tr > sr * MAX_UPSAMPLE) clip_mode = MODE_REJECT;
            else if (tr == sr) clip_mode = MODE_PASS;
            else clip_mode = MODE_INTERP;
            t = s * tr / sr;
            if (t > COUNT_MAX) t = COUNT_MAX;
            tgt_count  = t;
            pos_step   = (t >= 2) ? ((s << 16) / (t - 1)) : 0;
            pos_acc    = 0;
            frames_out = 0;
            clip_count++;
            mode_seen[int'(clip_mode)]++;
        end
        kpos   = frames_in << 16;
        at_end = (frames_in + 1 >= clip_len);
        if (clip_mode != MODE_INTERP) begin
            o.left_out     = (clip_mode == MODE_PASS) ? w.left_in : '0;
            o.right_out    = (clip_mode == MODE_PASS) ? w.right_in : '0;
            o.last_of_clip = at_end;
            o.status       = (clip_mode == MODE_REJECT);
            owed_words.push_back(typed ? typed_word : o);
        end else begin
            // on the final frame every owed output goes out, capped per word
            while (frames_out < tgt_count && n < MAX_RESULTS && (at_end || pos_acc <= kpos)) begin
                if (pos_acc >= kpos) begin
                    lo = cl;
                    ro = cr;
                end else begin
                    frac = pos_acc & 64'hFFFF;
                    lo = prev_l + (((cl - prev_l) * longint'(frac) + 32768) >>> 16);
                    ro = prev_r + (((cr - prev_r) * longint'(frac) + 32768) >>> 16);
                end
                o.left_out     = lo[SMP_W-1:0];
                o.right_out    = ro[SMP_W-1:0];
                o.last_of_clip = (frames_out + 1 == tgt_count);
                o.status       = 1'b0;
                owed_words.push_back(o);
                pos_acc += pos_step;
                frames_out++;
                n++;
            end
        end
        prev_l    = cl;
        prev_r    = cr;
        frames_in = at_end ? 0 : frames_in + 1;
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return '0;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return RATE_W'(1);
            2: return RATE_W'(192000);
            default: return '1;
        endcase
    endfunction

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (owed_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_W-1:0] idx, logic [RATE_W-1:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SOURCE_RATE:   cfg_src_rate   = val;
            CFG_TARGET_RATE:   cfg_tgt_rate   = val;
            CFG_SOURCE_FRAMES: cfg_src_frames = val[S_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_frame(t_in_word w, bit typed, t_out_word typed_word);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        resample_frame(w, typed, typed_word);
        frames_sent++;
        burst_left--;
        if (gap_max > 0 && burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
    endtask

    always @(posedge i_clk) begin
        if (cycles % 512 == 0) begin
            rx_mode <= 2'($urandom_range(0, 3));
            rx_pat  <= 8'($urandom) | 8'h01;
        end
        case (rx_mode)
            2'd0:    i_out_ready <= 1'b1;
            2'd1:    i_out_ready <= 1'($urandom_range(0, 1));
            2'd2:    i_out_ready <= rx_pat[cycles[2:0]];
            default: i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin : check_words
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_words.size() == 0) begin
                $display("%0t: word with none expected: %h", $time, o_out_word);
                mismatches++;
            end else begin
                want = owed_words.pop_front();
                words_checked++;
                if (o_out_word.left_out !== want.left_out) begin
                    $display("%0t: left_out expected %h got %h", $time,
                             want.left_out, o_out_word.left_out);
                    mismatches++;
                end
                if (o_out_word.right_out !== want.right_out) begin
                    $display("%0t: right_out expected %h got %h", $time,
                             want.right_out, o_out_word.right_out);
                    mismatches++;
                end
                if (o_out_word.last_of_clip !== want.last_of_clip) begin
                    $display("%0t: last_of_clip expected %b got %b", $time,
                             want.last_of_clip, o_out_word.last_of_clip);
                    mismatches++;
                end
                if (o_out_word.status !== want.status) begin
                    $display("%0t: status expected %b got %b", $time,
                             want.status, o_out_word.status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("%0t: timed out with %0d words outstanding", $time, owed_words.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        logic [RATE_W-1:0] sr, tr;
        logic [S_W-1:0]    sf;
        int                s_eff, nfr, goal;
        t_in_word          w;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            case (DIRECTED[i].kind)
                ROW_CFG:   write_reg(DIRECTED[i].idx, DIRECTED[i].data);
                ROW_TYPED: send_frame(DIRECTED[i].w, 1'b1, DIRECTED[i].want);
                default:   send_frame(DIRECTED[i].w, 1'b0, '0);
            endcase
        end

        goal = frames_sent + RANDOM_WORDS;
        while (frames_sent < goal) begin
            case ($urandom_range(0, 19))
                0, 1: sf = S_W'($urandom_range(9, 40));
                2:    sf = '0;
                default: sf = S_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0: begin
                    sr = RATE_W'($urandom_range(1, 192000));
                    tr = sr;
                end
                1: begin
                    sr = RATE_W'($urandom_range(1, 20000));
                    tr = RATE_W'($urandom_range(sr * 8 + 1, 262143));
                end
                2: begin
                    sr = pick_rate();
                    tr = pick_rate();
                end
                default: begin
                    sr = RATE_W'($urandom_range(1, 192000));
                    tr = RATE_W'($urandom_range((sr < 8) ? 1 : sr / 8,
                                                (sr * 8 > 262143) ? 262143 : sr * 8));
                end
            endcase
            write_reg(CFG_SOURCE_FRAMES, RATE_W'(sf));
            write_reg(CFG_SOURCE_RATE, sr);
            write_reg(CFG_TARGET_RATE, tr);
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            s_eff = (sf == 0) ? 1 : sf;
            // most phases send one whole clip; some break off early or run into the next
            nfr = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2 * s_eff) : s_eff;
            repeat (nfr) begin
                w.left_in  = pick_sample();
                w.right_in = pick_sample();
                send_frame(w, 1'b0, '0);
            end
        end

        // longest clip length; it is left unfinished
        write_reg(CFG_SOURCE_FRAMES, RATE_W'(17'h1FFFF));
        write_reg(CFG_SOURCE_RATE, RATE_W'(44100));
        write_reg(CFG_TARGET_RATE, RATE_W'(192000));
        repeat (24) begin
            w.left_in  = pick_sample();
            w.right_in = pick_sample();
            send_frame(w, 1'b0, '0);
        end
        wait_idle();

        $display("Sent %0d source frames over %0d clips: %0d interpolating, %0d pass, %0d rejected.",
                 frames_sent, clip_count, mode_seen[int'(MODE_INTERP)],
                 mode_seen[int'(MODE_PASS)], mode_seen[int'(MODE_REJECT)]);
        $display("Checked %0d result words, %0d mismatches.", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/lir_pkg.sv
hdl/lir_div.sv
hdl/lir_queue.sv
hdl/lir_front.sv
hdl/lir_back.sv
hdl/linear_interp_resampler_unit.sv
tb/sv/tb_linear_interp_resampler_unit.sv
